>>> hw/rtl/owbm_pkg.sv
// Package for the 1-Wire bus master: shared constants, request codes,
// configuration register indexes and the types passed between modules.
// Depends on nothing; the top level, front end and engine refer to it.
`timescale 1ns / 1ps
`default_nettype none

package owbm_pkg;

  // Width of the microsecond tick counter
  localparam int TIME_BITS = 10;

  // Configuration port geometry
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 3;

  // Depth of the queue between front end and engine
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Request codes carried by req_type
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_RESET = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ONE_LOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SLOT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SLOT     = 3'd6;

  // Reset values of the timing registers, in ticks
  localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd480;
  localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 10'd80;
  localparam logic [CFG_W-1:0] RST_RESET_TAIL    = 10'd400;
  localparam logic [CFG_W-1:0] RST_WRITE_ONE_LOW = 10'd1;
  localparam logic [CFG_W-1:0] RST_WRITE_SLOT    = 10'd50;
  localparam logic [CFG_W-1:0] RST_READ_LOW      = 10'd2;
  localparam logic [CFG_W-1:0] RST_READ_SLOT     = 10'd60;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low_us;
    logic [CFG_W-1:0] presence_wait_us;
    logic [CFG_W-1:0] reset_tail_us;
    logic [CFG_W-1:0] write_one_low_us;
    logic [CFG_W-1:0] write_slot_us;
    logic [CFG_W-1:0] read_low_us;
    logic [CFG_W-1:0] read_slot_us;
  } cfg_t;

  // Classified transaction as held in the queue
  typedef struct packed {
    logic       is_tick;
    logic [1:0] cmd;
    logic [7:0] wbyte;
    logic       line;
  } item_t;

endpackage

`default_nettype wire

>>> hw/rtl/owbm_if.sv
// Channel interfaces of the 1-Wire bus master: request and result streams
// with valid/ready handshake. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface owbm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] write_byte;
  logic       line_level;

  modport source (output valid, output req_type, output write_byte, output line_level,
                  input ready);
  modport sink (input valid, input req_type, input write_byte, input line_level,
                output ready);
endinterface

interface owbm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_byte;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output presence, output read_byte, input ready);
  modport sink (input valid, input drive_low, input busy_res, input done_res,
                input presence, input read_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/onewire_bus_master_top.sv
// Top level of the 1-Wire bus master: configuration registers, front end
// queue and timing engine. Uses owbm_pkg, owbm_if, owbm_front, owbm_engine.
`timescale 1ns / 1ps
`default_nettype none

// 1-Wire bus master, timed in microsecond ticks.
// in_if carries one transaction per item: a tick (req_type 0, with the
// sampled line level) or a command (reset, write byte, read byte). Commands
// start an operation only while idle and are otherwise ignored; ticks advance
// the bus timing. out_if returns exactly one result transaction per request:
// open-drain drive, busy, a done pulse, the presence flag and the last read
// byte, all showing the state after that request.
// A request passes from the queue to the engine, which registers its result.
// Throughput is one transaction per cycle while the receiver takes results:
// the timing engine does a counter increment and compare per tick.
// A two-entry queue parts request acceptance from the engine, and a result
// register parts the engine from the receiver. When the receiver stalls the
// result holds, the engine stops, and the queue fills; in_if.ready then drops.
// Reset (rst_n low at a clock edge) empties the queue and result register,
// returns the engine to idle and loads the default timing values.
// The cfg port writes timing register cfg_index with cfg_wdata whenever
// cfg_we is high; write it only while the block is idle.
module onewire_bus_master_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  owbm_in_if.sink                                in_if,
  owbm_out_if.source                             out_if,
  input  wire logic                              cfg_we,
  input  wire logic [owbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [owbm_pkg::CFG_W-1:0]        cfg_wdata
);

  owbm_pkg::cfg_t  cfg_r, cfg_nxt;
  owbm_pkg::item_t q_item;
  logic            q_valid;
  logic            q_pop;

  // decode a register write; indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        owbm_pkg::CFG_RESET_LOW:     cfg_nxt.reset_low_us     = cfg_wdata;
        owbm_pkg::CFG_PRESENCE_WAIT: cfg_nxt.presence_wait_us = cfg_wdata;
        owbm_pkg::CFG_RESET_TAIL:    cfg_nxt.reset_tail_us    = cfg_wdata;
        owbm_pkg::CFG_WRITE_ONE_LOW: cfg_nxt.write_one_low_us = cfg_wdata;
        owbm_pkg::CFG_WRITE_SLOT:    cfg_nxt.write_slot_us    = cfg_wdata;
        owbm_pkg::CFG_READ_LOW:      cfg_nxt.read_low_us      = cfg_wdata;
        owbm_pkg::CFG_READ_SLOT:     cfg_nxt.read_slot_us     = cfg_wdata;
        default:                     cfg_nxt                  = cfg_r;
      endcase
    end
  end

  // hold the timing registers; reset loads the standard bus timing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_us     <= owbm_pkg::RST_RESET_LOW;
      cfg_r.presence_wait_us <= owbm_pkg::RST_PRESENCE_WAIT;
      cfg_r.reset_tail_us    <= owbm_pkg::RST_RESET_TAIL;
      cfg_r.write_one_low_us <= owbm_pkg::RST_WRITE_ONE_LOW;
      cfg_r.write_slot_us    <= owbm_pkg::RST_WRITE_SLOT;
      cfg_r.read_low_us      <= owbm_pkg::RST_READ_LOW;
      cfg_r.read_slot_us     <= owbm_pkg::RST_READ_SLOT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // accept and classify requests, queue them for the engine
  owbm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // advance the bus timing and register one result per request
  owbm_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

`default_nettype wire

>>> hw/rtl/owbm_front.sv
// Front end of the 1-Wire bus master: accepts request transactions,
// classifies them and holds them in a short queue. Uses owbm_pkg, owbm_if.
`timescale 1ns / 1ps
`default_nettype none

module owbm_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  owbm_in_if.sink             in_if,
  output owbm_pkg::item_t     q_item,
  output logic                q_valid,
  input  wire logic           q_pop
);

  owbm_pkg::item_t                   q_mem_r [owbm_pkg::QDEPTH];
  logic [owbm_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [owbm_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [owbm_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                              push;
  owbm_pkg::item_t                   item_in;

  assign in_if.ready = (count_r < owbm_pkg::QCNT_W'(owbm_pkg::QDEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign q_valid     = (count_r != '0);
  assign q_item      = q_mem_r[rd_ptr_r];

  // classify: ticks carry the line, commands carry the byte
  always_comb begin
    item_in.is_tick = (in_if.req_type == owbm_pkg::REQ_TICK);
    item_in.cmd     = in_if.req_type;
    item_in.wbyte   = in_if.write_byte;
    item_in.line    = in_if.line_level;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == owbm_pkg::QPTR_W'(owbm_pkg::QDEPTH - 1)) ? '0
                                                                         : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == owbm_pkg::QPTR_W'(owbm_pkg::QDEPTH - 1)) ? '0
                                                                         : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> count_r != '0)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= owbm_pkg::QCNT_W'(owbm_pkg::QDEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/owbm_engine.sv
// Back end of the 1-Wire bus master: bus timing state machine and the
// result register. Uses owbm_pkg and owbm_out_if.
`timescale 1ns / 1ps
`default_nettype none

module owbm_engine (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire owbm_pkg::cfg_t cfg,
  input  wire owbm_pkg::item_t q_item,
  input  wire logic           q_valid,
  output logic                q_pop,
  owbm_out_if.source          out_if
);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_RLOW  = 4'd1;
  localparam logic [3:0] PH_RWAIT = 4'd2;
  localparam logic [3:0] PH_RTAIL = 4'd3;
  localparam logic [3:0] PH_WLOW  = 4'd4;
  localparam logic [3:0] PH_WREL  = 4'd5;
  localparam logic [3:0] PH_DLOW  = 4'd6;
  localparam logic [3:0] PH_DSAMP = 4'd7;
  localparam logic [3:0] PH_DWAIT = 4'd8;

  localparam int TB    = owbm_pkg::TIME_BITS;
  localparam int CMP_W = (TB > owbm_pkg::CFG_W) ? TB : owbm_pkg::CFG_W;
  localparam logic [TB-1:0] CNT_MAX = {TB{1'b1}};

  logic [3:0]    phase_r, phase_nxt;
  logic [TB-1:0] tick_r, tick_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic          pres_r, pres_nxt;
  logic [7:0]    last_rd_r, last_rd_nxt;
  logic          done_nxt;

  logic          out_valid_r;
  logic          drive_r, busy_r, done_r, pres_out_r;
  logic [7:0]    rbyte_r;

  logic [TB-1:0]               cnt_inc;
  logic [owbm_pkg::CFG_W-1:0]  lim;
  logic                        reached;
  logic                        cur_bit;
  logic                        take;

  assign take  = q_valid && (!out_valid_r || out_if.ready);
  assign q_pop = take;

  assign cnt_inc = (tick_r == CNT_MAX) ? tick_r : tick_r + 1'b1;
  assign cur_bit = shift_r[bit_r];

  always_comb begin
    unique case (phase_r)
      PH_RLOW:  lim = cfg.reset_low_us;
      PH_RWAIT: lim = cfg.presence_wait_us;
      PH_RTAIL: lim = cfg.reset_tail_us;
      PH_WLOW:  lim = cur_bit ? cfg.write_one_low_us : cfg.write_slot_us;
      PH_WREL:  lim = cfg.write_slot_us;
      PH_DLOW:  lim = cfg.read_low_us;
      default:  lim = cfg.read_slot_us;
    endcase
  end

  // a limit of zero acts as one; a limit past the counter range saturates
  assign reached = (CMP_W'(cnt_inc) >= CMP_W'(lim)) || (cnt_inc == CNT_MAX);

  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    pres_nxt    = pres_r;
    last_rd_nxt = last_rd_r;
    done_nxt    = 1'b0;
    if (q_item.is_tick) begin
      unique case (phase_r)
        PH_RLOW: begin
          tick_nxt = cnt_inc;
          if (reached) begin
            phase_nxt = PH_RWAIT;
            tick_nxt  = '0;
          end
        end
        PH_RWAIT: begin
          tick_nxt = cnt_inc;
          if (reached) begin
            pres_nxt  = ~q_item.line;
            phase_nxt = PH_RTAIL;
            tick_nxt  = '0;
          end
        end
        PH_RTAIL: begin
          tick_nxt = cnt_inc;
          if (reached) begin
            phase_nxt = PH_IDLE;
            tick_nxt  = '0;
            done_nxt  = 1'b1;
          end
        end
        PH_WLOW, PH_WREL: begin
          tick_nxt = cnt_inc;
          if (reached) begin
            tick_nxt = '0;
            if (phase_r == PH_WLOW && cur_bit) begin
              phase_nxt = PH_WREL;
            end else if (bit_r == 3'd7) begin
              phase_nxt = PH_IDLE;
              done_nxt  = 1'b1;
            end else begin
              bit_nxt   = bit_r + 1'b1;
              phase_nxt = PH_WLOW;
            end
          end
        end
        PH_DLOW: begin
          tick_nxt = cnt_inc;
          if (reached) begin
            phase_nxt = PH_DSAMP;
            tick_nxt  = '0;
          end
        end
        PH_DSAMP: begin
          if (q_item.line) begin
            shift_nxt[bit_r] = 1'b1;
          end
          phase_nxt = PH_DWAIT;
          tick_nxt  = '0;
        end
        PH_DWAIT: begin
          tick_nxt = cnt_inc;
          if (reached) begin
            tick_nxt = '0;
            if (bit_r == 3'd7) begin
              last_rd_nxt = shift_r;
              phase_nxt   = PH_IDLE;
              done_nxt    = 1'b1;
            end else begin
              bit_nxt   = bit_r + 1'b1;
              phase_nxt = PH_DLOW;
            end
          end
        end
        default: begin
          // idle, or a code outside the phase set: drop the tick
        end
      endcase
    end else if (phase_r == PH_IDLE) begin
      tick_nxt = '0;
      bit_nxt  = '0;
      unique case (q_item.cmd)
        owbm_pkg::REQ_RESET: begin
          pres_nxt  = 1'b0;
          phase_nxt = PH_RLOW;
        end
        owbm_pkg::REQ_WRITE: begin
          shift_nxt = q_item.wbyte;
          phase_nxt = PH_WLOW;
        end
        owbm_pkg::REQ_READ: begin
          shift_nxt = '0;
          phase_nxt = PH_DLOW;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      bit_r       <= '0;
      shift_r     <= '0;
      pres_r      <= 1'b0;
      last_rd_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r   <= phase_nxt;
        tick_r    <= tick_nxt;
        bit_r     <= bit_nxt;
        shift_r   <= shift_nxt;
        pres_r    <= pres_nxt;
        last_rd_r <= last_rd_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      drive_r    <= (phase_nxt == PH_RLOW) || (phase_nxt == PH_WLOW) ||
                    (phase_nxt == PH_DLOW);
      busy_r     <= (phase_nxt != PH_IDLE);
      done_r     <= done_nxt;
      pres_out_r <= pres_nxt;
      rbyte_r    <= last_rd_nxt;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.drive_low = drive_r;
  assign out_if.busy_res  = busy_r;
  assign out_if.done_res  = done_r;
  assign out_if.presence  = pres_out_r;
  assign out_if.read_byte = rbyte_r;

`ifndef ASSERT_OFF
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> !busy_r)
    else $error("done reported while still busy");

  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && drive_r |-> busy_r)
    else $error("bus driven low while idle");

  a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> tick_r == '0)
    else $error("tick counter not cleared in idle");
`endif

endmodule

`default_nettype wire
